// ===== rtl/salu_pkg.sv =====
// Package for the four-lane vector ALU: lane geometry, operation codes
// and the per-lane result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package salu_pkg;

  localparam int unsigned Lanes     = 4;
  localparam int unsigned LaneWidth = 64;
  localparam int unsigned ShiftBits = $clog2(LaneWidth);
  localparam int unsigned MulLo     = LaneWidth / 2;
  localparam int unsigned MulHi     = LaneWidth - MulLo;
  // Stage 0 holds operands, one divide step per later stage
  localparam int unsigned Stages    = LaneWidth + 1;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0,
    ACT_SUB = 4'd1,
    ACT_MUL = 4'd2,
    ACT_DIV = 4'd3,
    ACT_MOD = 4'd4,
    ACT_AND = 4'd5,
    ACT_OR  = 4'd6,
    ACT_XOR = 4'd7,
    ACT_NOT = 4'd8,
    ACT_SHL = 4'd9,
    ACT_SHR = 4'd10,
    ACT_CMP = 4'd11
  } act_e;

  typedef struct packed {
    logic [LaneWidth-1:0] res;
    logic                 eq;
    logic                 dz;
  } lane_out_t;

endpackage

`default_nettype wire

// ===== rtl/salu_lane.sv =====
// One ALU lane: operand stage, one restoring-divide step per stage, a
// split multiplier over two stages, and result select. Uses salu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module salu_lane
  import salu_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [3:0]           op_i,
  input  wire logic [LaneWidth-1:0] a_i,
  input  wire logic [LaneWidth-1:0] b_i,
  output lane_out_t                 out_o
);

  localparam int unsigned W = LaneWidth;

  // Per-stage payload
  logic [W-1:0] aq_q  [Stages];
  logic [W-1:0] rem_q [Stages];
  logic [W-1:0] b_q   [Stages];
  act_e         op_q  [Stages];
  logic         eq_q  [Stages];
  logic         dz_q  [Stages];
  logic [W-1:0] res_q [1:Stages-1];

  logic [W-1:0] aq_d  [Stages-1];
  logic [W-1:0] rem_d [Stages-1];

  logic [W-1:0]     simple_d;
  logic [W-1:0]     p0_q, p0_d;
  logic [MulHi-1:0] p1_q, p2_q;
  logic [MulHi-1:0] cross_sum;
  logic [W-1:0]     mul_sum;
  logic [W-1:0]     lo_a, lo_b;

  // One quotient bit per stage
  for (genvar j = 0; j < Stages - 1; j++) begin : g_div
    logic [W:0] rx;
    logic [W:0] rsub;
    logic       ge;
    always_comb begin
      rx        = {rem_q[j], aq_q[j][W-1]};
      rsub      = rx - {1'b0, b_q[j]};
      ge        = rx >= {1'b0, b_q[j]};
      rem_d[j]  = ge ? rsub[W-1:0] : rx[W-1:0];
      aq_d[j]   = {aq_q[j][W-2:0], ge};
    end
  end

  // Simple operations computed from the operand stage
  always_comb begin
    unique case (op_q[0])
      ACT_ADD: simple_d = aq_q[0] + b_q[0];
      ACT_SUB: simple_d = aq_q[0] - b_q[0];
      ACT_AND: simple_d = aq_q[0] & b_q[0];
      ACT_OR:  simple_d = aq_q[0] | b_q[0];
      ACT_XOR: simple_d = aq_q[0] ^ b_q[0];
      ACT_NOT: simple_d = ~aq_q[0];
      ACT_SHL: simple_d = (b_q[0] >= W) ? '0 : (aq_q[0] << b_q[0][ShiftBits-1:0]);
      ACT_SHR: simple_d = (b_q[0] >= W) ? '0 : (aq_q[0] >> b_q[0][ShiftBits-1:0]);
      default: simple_d = '0;
    endcase
  end

  // Low product as three partial products, summed one stage later
  assign lo_a      = W'(aq_q[0][MulLo-1:0]);
  assign lo_b      = W'(b_q[0][MulLo-1:0]);
  assign p0_d      = lo_a * lo_b;
  assign cross_sum = p1_q + p2_q;
  assign mul_sum   = p0_q + {cross_sum, {MulLo{1'b0}}};

  // Advance every stage together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aq_q[0]  <= a_i;
      rem_q[0] <= '0;
      b_q[0]   <= b_i;
      op_q[0]  <= act_e'(op_i);
      eq_q[0]  <= (act_e'(op_i) == ACT_CMP) && (a_i == b_i);
      dz_q[0]  <= ((act_e'(op_i) == ACT_DIV) || (act_e'(op_i) == ACT_MOD)) && (b_i == '0);
      p0_q     <= p0_d;
      p1_q     <= MulHi'(aq_q[0][W-1:MulLo] * b_q[0][MulHi-1:0]);
      p2_q     <= MulHi'(aq_q[0][MulHi-1:0] * b_q[0][W-1:MulLo]);
      res_q[1] <= simple_d;
      res_q[2] <= (op_q[1] == ACT_MUL) ? mul_sum : res_q[1];
      for (int j = 0; j < Stages - 1; j++) begin
        aq_q[j+1]  <= aq_d[j];
        rem_q[j+1] <= rem_d[j];
        b_q[j+1]   <= b_q[j];
        op_q[j+1]  <= op_q[j];
        eq_q[j+1]  <= eq_q[j];
        dz_q[j+1]  <= dz_q[j];
      end
      for (int j = 2; j < Stages - 1; j++) begin
        res_q[j+1] <= res_q[j];
      end
    end
  end

  // Pick the lane result at the last stage
  always_comb begin
    out_o.eq = eq_q[Stages-1];
    out_o.dz = dz_q[Stages-1];
    unique case (op_q[Stages-1])
      ACT_DIV: out_o.res = aq_q[Stages-1];
      ACT_MOD: out_o.res = rem_q[Stages-1];
      default: out_o.res = res_q[Stages-1];
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/salu_merge.sv =====
// Output stage: combines lane flags and holds the result until transfer.
// Uses salu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module salu_merge
  import salu_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 vld_i,
  input  wire lane_out_t            lane_i [Lanes],
  input  wire logic                 out_ready_i,
  output logic                      adv_o,
  output logic                      out_valid_o,
  output logic [LaneWidth-1:0]      r_o [Lanes],
  output logic                      all_equal_o,
  output logic                      divide_by_zero_o
);

  logic                 valid_q;
  logic [LaneWidth-1:0] r_q [Lanes];
  logic                 eq_q, dz_q;
  logic                 eq_d, dz_d;

  // Reduce lane flags
  always_comb begin
    eq_d = 1'b1;
    dz_d = 1'b0;
    for (int i = 0; i < Lanes; i++) begin
      eq_d = eq_d & lane_i[i].eq;
      dz_d = dz_d | lane_i[i].dz;
    end
  end

  assign adv_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= vld_i;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      for (int i = 0; i < Lanes; i++) begin
        r_q[i] <= lane_i[i].res;
      end
      eq_q <= eq_d;
      dz_q <= dz_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign r_o              = r_q;
  assign all_equal_o      = eq_q;
  assign divide_by_zero_o = dz_q;

endmodule

`default_nettype wire

// ===== rtl/simd_four_lane_u64_alu_core.sv =====
// From input transfer to result valid: operand stage loaded at the transfer,
// 64 divide stages, output register; every operation takes the same path.
// Throughput: one item per cycle; the whole pipe stalls only while a result
// waits at the output. Reset (rst_ni, async, active low) empties the pipe.
// Top level of the four-lane ALU. Uses salu_pkg, salu_lane, salu_merge.
`timescale 1ns / 1ps
`default_nettype none

module simd_four_lane_u64_alu_core
  import salu_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [3:0]           action_i,
  input  wire logic [LaneWidth-1:0] a_lane0_i,
  input  wire logic [LaneWidth-1:0] a_lane1_i,
  input  wire logic [LaneWidth-1:0] a_lane2_i,
  input  wire logic [LaneWidth-1:0] a_lane3_i,
  input  wire logic [LaneWidth-1:0] b_lane0_i,
  input  wire logic [LaneWidth-1:0] b_lane1_i,
  input  wire logic [LaneWidth-1:0] b_lane2_i,
  input  wire logic [LaneWidth-1:0] b_lane3_i,
  input  wire logic                 broadcast_b_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [LaneWidth-1:0]      r_lane0_o,
  output logic [LaneWidth-1:0]      r_lane1_o,
  output logic [LaneWidth-1:0]      r_lane2_o,
  output logic [LaneWidth-1:0]      r_lane3_o,
  output logic                      all_equal_o,
  output logic                      divide_by_zero_o
);

  logic [LaneWidth-1:0] a_vec [Lanes];
  logic [LaneWidth-1:0] b_vec [Lanes];
  logic [LaneWidth-1:0] r_vec [Lanes];
  lane_out_t            lane_out [Lanes];
  logic [Stages-1:0]    vld_q;
  logic                 adv;

  // Select the scalar or vector B operand
  assign a_vec[0] = a_lane0_i;
  assign a_vec[1] = a_lane1_i;
  assign a_vec[2] = a_lane2_i;
  assign a_vec[3] = a_lane3_i;
  assign b_vec[0] = b_lane0_i;
  assign b_vec[1] = broadcast_b_i ? b_lane0_i : b_lane1_i;
  assign b_vec[2] = broadcast_b_i ? b_lane0_i : b_lane2_i;
  assign b_vec[3] = broadcast_b_i ? b_lane0_i : b_lane3_i;

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    salu_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .op_i  (action_i),
      .a_i   (a_vec[i]),
      .b_i   (b_vec[i]),
      .out_o (lane_out[i])
    );
  end

  // Track occupied stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  salu_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vld_i            (vld_q[Stages-1]),
    .lane_i           (lane_out),
    .out_ready_i      (out_ready_i),
    .adv_o            (adv),
    .out_valid_o      (out_valid_o),
    .r_o              (r_vec),
    .all_equal_o      (all_equal_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  assign in_ready_o = adv;
  assign r_lane0_o  = r_vec[0];
  assign r_lane1_o  = r_vec[1];
  assign r_lane2_o  = r_vec[2];
  assign r_lane3_o  = r_vec[3];

endmodule

`default_nettype wire

// ===== rtl/salu_checker.sv =====
// Port-level checks for the four-lane ALU and the bind that attaches them.
// Uses salu_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module salu_checker
  import salu_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [LaneWidth-1:0] r_lane0_o,
  input wire logic [LaneWidth-1:0] r_lane1_o,
  input wire logic [LaneWidth-1:0] r_lane2_o,
  input wire logic [LaneWidth-1:0] r_lane3_o,
  input wire logic                 all_equal_o,
  input wire logic                 divide_by_zero_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input side opens whenever the output slot is free or draining
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");

  // Compare results carry zero lanes
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_equal_o |->
      r_lane0_o == '0 && r_lane1_o == '0 && r_lane2_o == '0 && r_lane3_o == '0)
    else $error("compare result with nonzero lane");

  // Flags belong to different operations
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(all_equal_o && divide_by_zero_o))
    else $error("both flags set");

endmodule

bind simd_four_lane_u64_alu_core salu_checker u_salu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .r_lane0_o        (r_lane0_o),
  .r_lane1_o        (r_lane1_o),
  .r_lane2_o        (r_lane2_o),
  .r_lane3_o        (r_lane3_o),
  .all_equal_o      (all_equal_o),
  .divide_by_zero_o (divide_by_zero_o)
);

`default_nettype wire
